[rtl/gha_pkg.sv]
// shared widths, codes and state encoding for the generational handle allocator
package gha_pkg;

    localparam int FUNC_W    = 1;
    localparam int IDX_W     = 10;
    localparam int GEN_OUT_W = 8;
    localparam int ST_W      = 2;
    localparam int RSV_W     = 11;

    localparam logic [RSV_W-1:0] RSV_RESET = 11'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACQUIRE = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RING_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RING,
        S_GEN,
        S_DONE
    } t_state;

endpackage

[rtl/gha_req_if.sv]
// request channel: operation and index to release
interface gha_req_if;
    logic                        valid;
    logic                        ready;
    logic [gha_pkg::FUNC_W-1:0]  func;
    logic [gha_pkg::IDX_W-1:0]   release_index;

    modport source (output valid, output func, output release_index, input ready);
    modport sink   (input valid, input func, input release_index, output ready);
endinterface

[rtl/gha_rsp_if.sv]
// response channel: granted handle and status
interface gha_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [gha_pkg::IDX_W-1:0]      handle_index;
    logic [gha_pkg::GEN_OUT_W-1:0]  handle_generation;
    logic [gha_pkg::ST_W-1:0]       status;

    modport source (output valid, output handle_index, output handle_generation,
                    output status, input ready);
    modport sink   (input valid, input handle_index, input handle_generation,
                    input status, output ready);
endinterface

[rtl/gha_ram.sv]
// generic simple dual-port ram with registered read
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/generational_handle_allocator.sv]
// generational handle allocator: free-index ring and generation table in ram
//
//   beat       direction  payload                                        handshake
//   i_req      in         func, release_index                            valid/ready
//   o_rsp      out        handle_index, handle_generation, status        valid/ready
//   i_cfg      in         free_reserve (i_cfg_wr_data)                   i_cfg_wr_en
//
// one item at a time: a fresh-index acquire, a failed acquire or an out-of-range
// release go from S_IDLE to S_DONE, a release through S_GEN (generation table
// read-modify-write), an acquire from the ring through S_RING and S_GEN (ring read,
// then generation table read); after reset a clearing pass writes every generation
// entry, during which i_req.ready is low; the config register is written at any time
// the result register lets the next beat in while a result waits on o_rsp
module generational_handle_allocator #(
    parameter int MAX_ENTRIES = 1024,
    parameter int GEN_BITS    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gha_req_if.sink                   i_req,
    gha_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [gha_pkg::RSV_W-1:0] i_cfg_wr_data
);

    localparam int IW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int IDXW   = gha_pkg::IDX_W;
    localparam int GENW   = gha_pkg::GEN_OUT_W;
    localparam int RELW   = gha_pkg::IDX_W;
    localparam int XW     = (IW > RELW) ? IW : RELW;

    gha_pkg::t_state  r_state, n_state;
    logic [IW-1:0]    r_clr, n_clr;
    logic [IW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_used, n_used;
    logic [gha_pkg::RSV_W-1:0] r_reserve;
    logic             r_is_acq, n_is_acq;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_res_idx, n_res_idx;
    logic [GEN_BITS-1:0] r_res_gen, n_res_gen;
    gha_pkg::t_status r_res_st, n_res_st;
    logic             r_out_valid, n_out_valid;
    logic [IW-1:0]    r_out_idx, n_out_idx;
    logic [GEN_BITS-1:0] r_out_gen, n_out_gen;
    gha_pkg::t_status r_out_st, n_out_st;

    logic                gen_we, gen_re;
    logic [IW-1:0]       gen_waddr, gen_raddr;
    logic [GEN_BITS-1:0] gen_wdata, gen_rdata;
    logic                ring_we, ring_re;
    logic [IW-1:0]       ring_waddr, ring_rdata;

    logic            w_in_acc;
    logic            w_acquire;
    logic            w_reuse;
    logic            w_can_bump;
    logic            w_in_range;
    logic            w_ring_room;
    logic            w_out_free;
    logic [XW-1:0]   w_rel_x;
    logic [IW-1:0]   w_rel_idx;
    logic [CW:0]     w_sum;
    logic [IW-1:0]   w_tail;
    logic [IW-1:0]   w_head_inc;

    assign i_req.ready = (r_state == gha_pkg::S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_acquire   = (i_req.func == gha_pkg::FUNC_ACQUIRE);
    assign w_reuse     = 32'(r_count) > 32'(r_reserve);
    assign w_can_bump  = 32'(r_used) < 32'(MAX_ENTRIES);
    assign w_rel_x     = XW'(i_req.release_index);
    assign w_in_range  = 32'(w_rel_x) < 32'(MAX_ENTRIES);
    assign w_rel_idx   = IW'(w_rel_x);
    assign w_ring_room = 32'(r_count) < 32'(MAX_ENTRIES);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_sum      = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign w_tail     = (w_sum >= (CW+1)'(MAX_ENTRIES))
                        ? IW'(w_sum - (CW+1)'(MAX_ENTRIES)) : IW'(w_sum);
    assign w_head_inc = (r_head == IW'(MAX_ENTRIES - 1)) ? '0 : r_head + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gha_pkg::S_CLEAR: begin
                if (r_clr == IW'(MAX_ENTRIES - 1)) begin
                    n_state = gha_pkg::S_IDLE;
                end
            end
            gha_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_acquire) begin
                        n_state = w_reuse ? gha_pkg::S_RING : gha_pkg::S_DONE;
                    end else begin
                        n_state = w_in_range ? gha_pkg::S_GEN : gha_pkg::S_DONE;
                    end
                end
            end
            gha_pkg::S_RING: n_state = gha_pkg::S_GEN;
            gha_pkg::S_GEN:  n_state = gha_pkg::S_DONE;
            gha_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = gha_pkg::S_IDLE;
                end
            end
            default: n_state = gha_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        gen_we     = 1'b0;
        gen_waddr  = r_clr;
        gen_wdata  = GEN_BITS'(1);
        gen_re     = 1'b0;
        gen_raddr  = w_rel_idx;
        ring_we    = 1'b0;
        ring_waddr = w_tail;
        ring_re    = 1'b0;
        n_clr      = r_clr;
        n_head     = r_head;
        n_count    = r_count;
        n_used     = r_used;
        n_is_acq   = r_is_acq;
        n_idx      = r_idx;
        n_res_idx  = r_res_idx;
        n_res_gen  = r_res_gen;
        n_res_st   = r_res_st;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_idx  = r_out_idx;
        n_out_gen  = r_out_gen;
        n_out_st   = r_out_st;
        case (r_state)
            gha_pkg::S_CLEAR: begin
                gen_we = 1'b1;
                n_clr  = r_clr + 1'b1;
            end
            gha_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_is_acq  = w_acquire;
                    n_res_idx = '0;
                    n_res_gen = '0;
                    n_res_st  = gha_pkg::ST_OK;
                    if (w_acquire) begin
                        if (w_reuse) begin
                            ring_re = 1'b1;
                            n_head  = w_head_inc;
                            n_count = r_count - 1'b1;
                        end else if (w_can_bump) begin
                            gen_we    = 1'b1;
                            gen_waddr = IW'(r_used);
                            n_res_idx = IW'(r_used);
                            n_res_gen = GEN_BITS'(1);
                            n_used    = r_used + 1'b1;
                        end else begin
                            n_res_st = gha_pkg::ST_EXHAUSTED;
                        end
                    end else if (w_in_range) begin
                        gen_re = 1'b1;
                        n_idx  = w_rel_idx;
                        if (w_ring_room) begin
                            ring_we = 1'b1;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_res_st = gha_pkg::ST_RING_FULL;
                        end
                    end
                end
            end
            gha_pkg::S_RING: begin
                gen_re    = 1'b1;
                gen_raddr = ring_rdata;
                n_idx     = ring_rdata;
                n_res_idx = ring_rdata;
            end
            gha_pkg::S_GEN: begin
                if (r_is_acq) begin
                    n_res_gen = gen_rdata;
                end else begin
                    gen_we    = 1'b1;
                    gen_waddr = r_idx;
                    gen_wdata = gen_rdata + 1'b1;
                end
            end
            gha_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_gen   = r_res_gen;
                    n_out_st    = r_res_st;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gha_pkg::S_CLEAR;
            r_clr       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_used      <= '0;
            r_reserve   <= gha_pkg::RSV_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_count     <= n_count;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_reserve <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_acq  <= n_is_acq;
        r_idx     <= n_idx;
        r_res_idx <= n_res_idx;
        r_res_gen <= n_res_gen;
        r_res_st  <= n_res_st;
        r_out_idx <= n_out_idx;
        r_out_gen <= n_out_gen;
        r_out_st  <= n_out_st;
    end

    gha_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_gen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (gen_we),
        .i_wr_addr (gen_waddr),
        .i_wr_data (gen_wdata),
        .i_rd_en   (gen_re),
        .i_rd_addr (gen_raddr),
        .o_rd_data (gen_rdata)
    );

    gha_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_ENTRIES)
    ) u_ring_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ring_we),
        .i_wr_addr (ring_waddr),
        .i_wr_data (w_rel_idx),
        .i_rd_en   (ring_re),
        .i_rd_addr (r_head),
        .o_rd_data (ring_rdata)
    );

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.handle_index      = IDXW'(r_out_idx);
    assign o_rsp.handle_generation = GENW'(r_out_gen);
    assign o_rsp.status            = r_out_st;

endmodule

[rtl/gha_chk.sv]
// port-level checker for the generational handle allocator, bound to the top level
module gha_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [gha_pkg::IDX_W-1:0]     i_out_index,
    input logic [gha_pkg::GEN_OUT_W-1:0] i_out_gen,
    input logic [gha_pkg::ST_W-1:0]      i_out_status
);

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == gha_pkg::ST_EXHAUSTED)
        |-> (i_out_index == '0 && i_out_gen == '0))
        else $error("exhausted acquire carries a nonzero handle");

    a_ring_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == gha_pkg::ST_RING_FULL)
        |-> (i_out_index == '0 && i_out_gen == '0))
        else $error("ring-full release carries a nonzero handle");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while previous beat still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready)
        |=> (i_out_valid && $stable(i_out_index) && $stable(i_out_gen)
             && $stable(i_out_status)))
        else $error("stalled response beat changed");

endmodule

bind generational_handle_allocator gha_chk u_gha_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_index  (o_rsp.handle_index),
    .i_out_gen    (o_rsp.handle_generation),
    .i_out_status (o_rsp.status)
);

[bench/gha_grant_checker.sv]
// grant checker: predicts every response beat of the handle allocator and compares it
`timescale 1ns / 100ps

module gha_grant_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gha_req_if                        i_req,
    gha_rsp_if                        i_rsp,
    input  logic                      i_cfg_wr_en,
    input  logic [gha_pkg::RSV_W-1:0] i_cfg_wr_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int TABLE_SIZE = 1024;

    typedef struct packed {
        logic [gha_pkg::IDX_W-1:0]     index;
        logic [gha_pkg::GEN_OUT_W-1:0] generation;
        gha_pkg::t_status              status;
    } t_grant;

    logic [gha_pkg::GEN_OUT_W-1:0] gen_table [TABLE_SIZE];
    logic [gha_pkg::IDX_W-1:0]     free_ring [TABLE_SIZE];
    logic [gha_pkg::IDX_W-1:0]     ring_head;
    logic [gha_pkg::RSV_W-1:0]     ring_count;
    logic [gha_pkg::RSV_W-1:0]     used_count;
    logic [gha_pkg::RSV_W-1:0]     reserve;
    t_grant                        grant_q [$];

    function automatic t_grant predict_grant(input gha_pkg::t_func f,
                                             input logic [gha_pkg::IDX_W-1:0] ri);
        t_grant                    g;
        logic [gha_pkg::IDX_W-1:0] slot;
        g = '0;
        if (f == gha_pkg::FUNC_ACQUIRE) begin
            if (ring_count > reserve) begin
                slot         = free_ring[ring_head];
                ring_head    = ring_head + 1'b1;
                ring_count   = ring_count - 1'b1;
                g.index      = slot;
                g.generation = gen_table[slot];
            end else if (used_count < TABLE_SIZE) begin
                slot            = used_count[gha_pkg::IDX_W-1:0];
                used_count      = used_count + 1'b1;
                gen_table[slot] = 8'd1;
                g.index         = slot;
                g.generation    = 8'd1;
            end else begin
                g.status = gha_pkg::ST_EXHAUSTED;
            end
        end else begin
            gen_table[ri] = gen_table[ri] + 1'b1;
            if (ring_count == TABLE_SIZE) begin
                g.status = gha_pkg::ST_RING_FULL;
            end else begin
                slot            = ring_head + ring_count[gha_pkg::IDX_W-1:0];
                free_ring[slot] = ri;
                ring_count      = ring_count + 1'b1;
            end
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_SIZE; k++) gen_table[k] = 8'd1;
            reserve      = gha_pkg::RSV_RESET;
            ring_head    = '0;
            ring_count   = '0;
            used_count   = '0;
            o_fail_count = 0;
            grant_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (grant_q.size() == 0) begin
                    $error("response beat with nothing expected: index %0d status %0d",
                           i_rsp.handle_index, i_rsp.status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = grant_q[0];
                    grant_q.delete(0);
                    if (i_rsp.handle_index !== want.index) begin
                        $error("handle_index: expected %0d, actual %0d",
                               want.index, i_rsp.handle_index);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.handle_generation !== want.generation) begin
                        $error("handle_generation: expected %0d, actual %0d",
                               want.generation, i_rsp.handle_generation);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_rsp.status);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                grant_q = {grant_q,
                           predict_grant(gha_pkg::t_func'(i_req.func), i_req.release_index)};
            end
            if (i_cfg_wr_en) begin
                reserve = i_cfg_wr_data;
            end
        end
        o_pending = grant_q.size();
    end

endmodule

[bench/generational_handle_allocator_tb.sv]
// testbench top: stimulus, idling and verdict for the generational handle allocator
`timescale 1ns / 100ps

module generational_handle_allocator_tb;

    localparam int TIMEOUT_CYCLES = 500000;
    localparam int HOLD_CYCLES    = 300;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      cfg_wr_en;
    logic [gha_pkg::RSV_W-1:0] cfg_wr_data;

    int   fail_count;
    int   pending_count;
    int   cycle_count;
    int   tx_idle_pct;
    int   rx_idle_pct;
    logic pressure_arm;
    logic rx_hold;

    logic [gha_pkg::IDX_W-1:0] live_pool [$];
    gha_pkg::t_func            func_q [$];

    gha_req_if req_bus ();
    gha_rsp_if rsp_bus ();

    generational_handle_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .o_rsp         (rsp_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    gha_grant_checker u_grant_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .i_rsp         (rsp_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // long receiver hold-off so the block backs up into its request port
    initial begin
        rx_hold = 1'b0;
        wait (pressure_arm);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(negedge i_clk) begin
        rsp_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // granted indices feed well-formed releases
    always @(posedge i_clk) begin
        gha_pkg::t_func f;
        if (rsp_bus.valid && rsp_bus.ready && func_q.size() != 0) begin
            f = func_q[0];
            func_q.delete(0);
            if (f == gha_pkg::FUNC_ACQUIRE && rsp_bus.status == gha_pkg::ST_OK) begin
                live_pool = {live_pool, rsp_bus.handle_index};
            end
        end
    end

    task automatic send_beat(input gha_pkg::t_func f, input logic [gha_pkg::IDX_W-1:0] ri);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.func          <= f;
        req_bus.release_index <= ri;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        func_q = {func_q, f};
        @(negedge i_clk);
    endtask

    task automatic acquire_handle();
        send_beat(gha_pkg::FUNC_ACQUIRE, gha_pkg::IDX_W'($urandom));
    endtask

    task automatic release_handle(input logic [gha_pkg::IDX_W-1:0] ri);
        send_beat(gha_pkg::FUNC_RELEASE, ri);
    endtask

    task automatic drain_and_set_reserve(input logic [gha_pkg::RSV_W-1:0] value);
        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int acq_pct, input int hot_pct,
                             input int noise_pct);
        int                        roll;
        int                        pick;
        logic [gha_pkg::IDX_W-1:0] ri;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < acq_pct) begin
                acquire_handle();
            end else begin
                ri   = gha_pkg::IDX_W'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < hot_pct) begin
                    ri = gha_pkg::IDX_W'($urandom_range(0, 1));
                end else if (roll >= hot_pct + noise_pct && live_pool.size() != 0) begin
                    pick = $urandom_range(0, live_pool.size() - 1);
                    ri   = live_pool[pick];
                    live_pool.delete(pick);
                end
                release_handle(ri);
            end
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        req_bus.valid         = 1'b0;
        req_bus.func          = gha_pkg::FUNC_ACQUIRE;
        req_bus.release_index = '0;
        pressure_arm          = 1'b0;
        tx_idle_pct           = 14;
        rx_idle_pct           = 71;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset reserve: nothing is reused yet, duplicates and a never-granted index enter
        acquire_handle();
        acquire_handle();
        acquire_handle();
        release_handle(10'd1);
        release_handle(10'd1);
        release_handle(10'd1023);
        release_handle(10'd0);
        acquire_handle();

        // zero reserve: ring drains oldest first, then falls back to the bump counter
        drain_and_set_reserve(11'd0);
        acquire_handle();
        acquire_handle();
        acquire_handle();
        acquire_handle();
        acquire_handle();
        release_handle(10'd4);
        acquire_handle();

        drain_and_set_reserve(11'd1);
        release_handle(10'd2);
        acquire_handle();
        release_handle(10'd3);
        acquire_handle();

        drain_and_set_reserve(11'd0);
        run_phase(25, 50, 5, 15);

        tx_idle_pct = 71;
        rx_idle_pct = 14;
        drain_and_set_reserve(gha_pkg::RSV_W'($urandom_range(2, 40)));
        run_phase(25, 50, 5, 15);

        // releases only, half to two hot indices: generations wrap and the ring overflows
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_and_set_reserve(11'd1024);
        pressure_arm = 1'b1;
        run_phase(1030, 0, 50, 10);

        // full ring drained by reuse
        drain_and_set_reserve(11'd0);
        run_phase(30, 55, 20, 20);

        req_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/gha_pkg.sv
rtl/gha_req_if.sv
rtl/gha_rsp_if.sv
rtl/gha_ram.sv
rtl/generational_handle_allocator.sv
rtl/gha_chk.sv
bench/gha_grant_checker.sv
bench/generational_handle_allocator_tb.sv
